FILE: design/dve_pkg.sv
package dve_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int SHORT_W    = 16;
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 3;
    localparam int APB_DATA_W = 32;
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // register index taken from paddr[2]
    localparam logic REG_SHORT_MODE = 1'b0;

    localparam logic [SAMPLE_W-1:0] MASK_LONG  = 32'hffff_ffff;
    localparam logic [SAMPLE_W-1:0] MASK_SHORT = 32'h0000_ffff;
    localparam logic [SAMPLE_W-1:0] MIN_LONG   = 32'h8000_0000;
    localparam logic [SAMPLE_W-1:0] MIN_SHORT  = 32'h0000_8000;

    typedef struct packed {
        logic                short_mode;
        logic [SAMPLE_W-1:0] diff;
    } t_diff_item;

    // queue push handshake, front to queue
    typedef struct packed {
        logic       vld;
        t_diff_item item;
    } t_q_push;

endpackage

FILE: design/dve_front.sv
module dve_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_short_mode,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dve_pkg::SAMPLE_W-1:0]    s_axis_tdata,   // [31:0] sample
    input  logic                            s_axis_tuser,   // [0] block_start
    input  logic                            i_q_full,
    output dve_pkg::t_q_push                o_push
);
    import dve_pkg::*;

    logic [SAMPLE_W-1:0] r_prev;
    logic [SAMPLE_W-1:0] n_prev;
    logic [SAMPLE_W-1:0] w_cur;
    logic [SAMPLE_W-1:0] w_base;
    logic [SAMPLE_W-1:0] w_mask;
    logic                w_take;

    assign s_axis_tready = !i_q_full;
    assign w_take        = s_axis_tvalid && !i_q_full;

    always_comb begin
        if (i_short_mode) begin
            w_cur  = {{(SAMPLE_W-SHORT_W){s_axis_tdata[SHORT_W-1]}},
                      s_axis_tdata[SHORT_W-1:0]};
            w_mask = MASK_SHORT;
        end else begin
            w_cur  = s_axis_tdata;
            w_mask = MASK_LONG;
        end
        w_base = s_axis_tuser ? '0 : r_prev;
        n_prev = w_take ? w_cur : r_prev;
        o_push.vld             = w_take;
        o_push.item.short_mode = i_short_mode;
        o_push.item.diff       = (w_cur - w_base) & w_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else begin
            r_prev <= n_prev;
        end
    end

endmodule

FILE: design/dve_fifo.sv
module dve_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dve_pkg::t_q_push    i_push,
    output logic                o_full,
    output logic                o_vld,
    output dve_pkg::t_diff_item o_item,
    input  logic                i_pop
);
    import dve_pkg::*;

    t_diff_item       r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_vld  = (r_count != '0);
    assign o_item = r_mem[r_rd_ptr];
    assign w_wr   = i_push.vld && !o_full;
    assign w_rd   = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.vld |-> !o_full)
        else $error("push into full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

FILE: design/dve_back.sv
module dve_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_vld,
    input  dve_pkg::t_diff_item         i_q_item,
    output logic                        o_q_pop,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [dve_pkg::BYTE_W-1:0]  m_axis_tdata,   // [7:0] code_byte
    output logic                        m_axis_tlast,   // last_of_sample
    output logic                        m_axis_tuser    // [0] clip_error
);
    import dve_pkg::*;

    logic                r_busy;
    logic [SAMPLE_W-1:0] r_rem;
    logic                r_sign;
    logic                r_clip;
    logic                r_first;
    logic                r_out_vld;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_last;
    logic                r_out_err;

    logic                w_emit;
    logic                w_load;
    logic                w_cont;
    logic                w_last;
    logic [BYTE_W-1:0]   w_byte;
    logic [SAMPLE_W-1:0] w_shift;
    logic [SAMPLE_W-1:0] w_mask;
    logic                w_hsign;
    logic                w_hclip;
    logic [SAMPLE_W-1:0] w_hmag;

    // decode the queue head
    always_comb begin
        if (i_q_item.short_mode) begin
            w_mask  = MASK_SHORT;
            w_hsign = i_q_item.diff[SHORT_W-1];
            w_hclip = (i_q_item.diff == MIN_SHORT);
        end else begin
            w_mask  = MASK_LONG;
            w_hsign = i_q_item.diff[SAMPLE_W-1];
            w_hclip = (i_q_item.diff == MIN_LONG);
        end
        w_hmag = w_hsign ? ((SAMPLE_W'(0) - i_q_item.diff) & w_mask) : i_q_item.diff;
    end

    // byte formatter
    always_comb begin
        if (r_clip) begin
            w_cont  = 1'b0;
            w_byte  = '0;
            w_shift = '0;
        end else if (r_first) begin
            w_cont  = |r_rem[SAMPLE_W-1:6];
            w_byte  = {w_cont, r_rem[5:0], r_sign};
            w_shift = r_rem >> 6;
        end else begin
            w_cont  = |r_rem[SAMPLE_W-1:7];
            w_byte  = {w_cont, r_rem[6:0]};
            w_shift = r_rem >> 7;
        end
        w_last = !w_cont;
    end

    assign w_emit  = r_busy && (!r_out_vld || m_axis_tready);
    assign w_load  = i_q_vld && (!r_busy || (w_emit && w_last));
    assign o_q_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
            end else if (w_emit && w_last) begin
                r_busy <= 1'b0;
            end
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rem   <= w_hmag;
            r_sign  <= w_hsign;
            r_clip  <= w_hclip;
            r_first <= 1'b1;
        end else if (w_emit) begin
            r_rem   <= w_shift;
            r_first <= 1'b0;
        end
        if (w_emit) begin
            r_out_byte <= w_byte;
            r_out_last <= w_last;
            r_out_err  <= r_clip;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_err;

    a_clip_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("clip word not a lone zero word");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && r_busy) |-> (w_emit && w_last))
        else $error("queue popped while a sample is still being sent");

endmodule

FILE: design/delta_varint_encoder_core.sv
// channel   | dir | handshake                | payload
// s_axis    | in  | s_axis_tvalid/tready     | tdata[31:0] sample, tuser block_start
// m_axis    | out | m_axis_tvalid/tready     | tdata[7:0] code_byte, tlast, tuser clip_error
// apb       | in  | psel/penable/pready      | paddr 0: short_sample_mode
//
// One sample yields 1 to 5 words; the back end sends one word per cycle while m_axis_tready is high.
// The front end differences a sample in the cycle it is taken and parks
// it in a two-entry queue; it stalls only when the queue is full.
// Reset clears the previous sample and short_sample_mode, empties the queue.
module delta_varint_encoder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [dve_pkg::SAMPLE_W-1:0]        s_axis_tdata,   // [31:0] sample
    input  logic                                s_axis_tuser,   // [0] block_start
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [dve_pkg::BYTE_W-1:0]          m_axis_tdata,   // [7:0] code_byte
    output logic                                m_axis_tlast,
    output logic                                m_axis_tuser,   // [0] clip_error
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dve_pkg::ADDR_W-1:0]          paddr,
    input  logic [dve_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [dve_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import dve_pkg::*;

    logic       r_short_mode;
    logic       w_cfg_wr;
    t_q_push    w_push;
    logic       w_q_full;
    logic       w_q_vld;
    t_diff_item w_q_item;
    logic       w_q_pop;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == REG_SHORT_MODE);
    assign prdata   = (paddr[2] == REG_SHORT_MODE)
                      ? {{(APB_DATA_W-1){1'b0}}, r_short_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_mode <= 1'b0;
        end else if (w_cfg_wr) begin
            r_short_mode <= pwdata[0];
        end
    end

    dve_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_short_mode  (r_short_mode),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (w_q_full),
        .o_push        (w_push)
    );

    dve_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_q_full),
        .o_vld   (w_q_vld),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    dve_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_vld       (w_q_vld),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
